// ----- sv/skts_pkg.sv -----
// Shared types and constants of the streaming k-smallest tracker.
package skts_pkg;

    localparam int VALUE_W = 32;
    localparam int KEEP_W  = 5;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // One queued beat: sample and its end-of-array mark
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_item;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ----- sv/skts_front.sv -----
// Front end: keep-count register, clamp, and input beat pass-through to the queue.
module skts_front #(
    parameter int MAX_KEPT = 16,
    parameter int FW       = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [skts_pkg::KEEP_W-1:0]    i_cfg_wr_data,
    input  logic                           i_s_valid,
    output logic                           o_s_ready,
    input  logic [skts_pkg::VALUE_W-1:0]   i_s_value,
    input  logic                           i_s_last,
    output logic                           o_q_valid,
    input  logic                           i_q_ready,
    output skts_pkg::t_item                o_q_item,
    output logic [FW-1:0]                  o_keep
);
    import skts_pkg::*;

    localparam int CW = (FW > KEEP_W) ? FW : KEEP_W;

    logic [KEEP_W-1:0] r_keep;
    logic              keep_over;

    // Hold the keep count; reset value is one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_W'(1);
        end else if (i_cfg_wr_en) begin
            r_keep <= i_cfg_wr_data;
        end
    end

    // Clamp the keep count to the store depth
    assign keep_over = CW'(r_keep) > CW'(MAX_KEPT);
    assign o_keep    = keep_over ? FW'(MAX_KEPT) : FW'(r_keep);

    // Pass beats into the queue as items
    assign o_q_valid      = i_s_valid;
    assign o_s_ready      = i_q_ready;
    assign o_q_item.value = i_s_value;
    assign o_q_item.last  = i_s_last;

endmodule

// ----- sv/skts_queue.sv -----
// Short register queue between the front and back ends.
module skts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  skts_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output skts_pkg::t_item o_pop_item
);
    import skts_pkg::*;

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = r_count != (Q_AW+1)'(Q_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_item   = r_mem[r_rd_ptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/skts_back.sv -----
// Back end: row of sorted cells with insertion, replacement and drain.
module skts_back #(
    parameter int MAX_KEPT = 16,
    parameter int FW       = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [FW-1:0]                i_keep,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  skts_pkg::t_item              i_q_item,
    output logic                         o_m_valid,
    input  logic                         i_m_ready,
    output logic [skts_pkg::VALUE_W-1:0] o_m_value,
    output logic                         o_m_last
);
    import skts_pkg::*;

    logic signed [VALUE_W-1:0] r_val [MAX_KEPT];
    logic [FW-1:0]             r_fill;
    logic [FW-1:0]             n_fill;
    t_state                    r_state;
    t_state                    n_state;

    logic signed [VALUE_W-1:0] v;
    logic                      take;
    logic                      do_ins;
    logic                      do_rep;
    logic                      drain_beat;
    logic                      cell_we;
    logic [MAX_KEPT-1:0]       g;
    logic signed [VALUE_W-1:0] ins_val   [MAX_KEPT];
    logic signed [VALUE_W-1:0] rep_val   [MAX_KEPT];
    logic signed [VALUE_W-1:0] shift_val [MAX_KEPT];
    logic signed [VALUE_W-1:0] cell_next [MAX_KEPT];

    assign v          = $signed(i_q_item.value);
    assign o_q_ready  = r_state == ST_RUN;
    assign take       = i_q_valid && o_q_ready;
    assign do_ins     = r_fill < i_keep;
    assign do_rep     = !do_ins && (r_fill != '0) && (v < r_val[0]);
    assign o_m_valid  = r_state == ST_DRAIN;
    assign o_m_value  = r_val[0];
    assign o_m_last   = r_fill == FW'(1);
    assign drain_beat = o_m_valid && i_m_ready;
    assign cell_we    = (take && (do_ins || do_rep)) || drain_beat;

    // Per-cell compare and next value for each operation
    for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
        logic signed [VALUE_W-1:0] prev_val;
        logic signed [VALUE_W-1:0] next_val;
        logic                      prev_g;
        logic                      next_g;

        assign g[i] = (FW'(i) < r_fill) && (r_val[i] >= v);

        if (i == 0) begin : g_first
            assign prev_val = v;
            assign prev_g   = 1'b1;
        end else begin : g_inner_prev
            assign prev_val = r_val[i-1];
            assign prev_g   = g[i-1];
        end

        if (i == MAX_KEPT - 1) begin : g_last
            assign next_val = r_val[i];
            assign next_g   = 1'b0;
        end else begin : g_inner_next
            assign next_val = r_val[i+1];
            assign next_g   = g[i+1];
        end

        // Insert: keep entries at or above the value, place the value, shift the rest down
        assign ins_val[i]   = g[i] ? r_val[i] : (prev_g ? v : prev_val);
        // Replace: drop the largest and insert in one move
        assign rep_val[i]   = next_g ? next_val : (g[i] ? v : r_val[i]);
        assign shift_val[i] = next_val;
        assign cell_next[i] = drain_beat ? shift_val[i] : (do_ins ? ins_val[i] : rep_val[i]);
    end

    // Update the cells
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            for (int i = 0; i < MAX_KEPT; i++) begin
                r_val[i] <= cell_next[i];
            end
        end
    end

    // Sequence item handling and drain
    always_comb begin
        n_fill  = r_fill;
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (take) begin
                    if (do_ins) begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (i_q_item.last) begin
                        if (do_ins || (r_fill != '0)) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (drain_beat) begin
                    n_fill = r_fill - 1'b1;
                    if (r_fill == FW'(1)) begin
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
                n_fill  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Fill never exceeds the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAX_KEPT))
        else $error("fill count beyond store depth");

    // Drain only runs with kept values present
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_fill != '0))
        else $error("drain with empty store");

    // A stalled result leaves the store untouched
    a_drain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && !i_m_ready) |=> ($stable(r_fill) && $stable(r_val[0])))
        else $error("store moved while result stalled");

    // Head of the store is the largest kept value
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill >= FW'(2)) |-> (r_val[0] >= r_val[1 % MAX_KEPT]))
        else $error("store out of order");

endmodule

// ----- sv/streaming_k_smallest_tracker.sv -----
// Top level of the streaming k-smallest tracker.
// Throughput: one sample per cycle into a four-entry queue while it is not full;
// the cell row takes one per cycle outside a drain.
// A marked sample passes through the queue and sets the drain state before the first result.
// Drain: one kept value per cycle with the sink ready, at most MAX_KEPT kept values;
// the cell row takes no sample until the drain ends.
// The queue keeps accepting samples during the drain until it is full.
// Reset (synchronous, active low) empties the store and queue and sets keep_count to one.
module streaming_k_smallest_tracker #(
    parameter int MAX_KEPT = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [skts_pkg::KEEP_W-1:0]  i_cfg_wr_data,   // keep_count
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [skts_pkg::VALUE_W-1:0] s_axis_tdata,    // [31:0] sample_value
    input  logic                         s_axis_tlast,    // end_of_array
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [skts_pkg::VALUE_W-1:0] m_axis_tdata,    // [31:0] kept_value
    output logic                         m_axis_tlast     // last_of_run
);
    import skts_pkg::*;

    localparam int FW = $clog2(MAX_KEPT + 1);

    logic          f_valid;
    logic          f_ready;
    t_item         f_item;
    logic          b_valid;
    logic          b_ready;
    t_item         b_item;
    logic [FW-1:0] keep;

    // Accept beats and hold the keep count
    skts_front #(
        .MAX_KEPT (MAX_KEPT),
        .FW       (FW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_valid     (s_axis_tvalid),
        .o_s_ready     (s_axis_tready),
        .i_s_value     (s_axis_tdata),
        .i_s_last      (s_axis_tlast),
        .o_q_valid     (f_valid),
        .i_q_ready     (f_ready),
        .o_q_item      (f_item),
        .o_keep        (keep)
    );

    // Decouple front and back
    skts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_item   (b_item)
    );

    // Sorted cells and drain
    skts_back #(
        .MAX_KEPT (MAX_KEPT),
        .FW       (FW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_keep    (keep),
        .i_q_valid (b_valid),
        .o_q_ready (b_ready),
        .i_q_item  (b_item),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_value (m_axis_tdata),
        .o_m_last  (m_axis_tlast)
    );

endmodule

// ----- sim/tb_streaming_k_smallest_tracker.sv -----
// Self-checking testbench for the streaming k-smallest tracker: directed table, then random arrays.
`timescale 1ns / 100ps

module tb_streaming_k_smallest_tracker;

    import skts_pkg::*;

    localparam int MAX_KEPT       = 16;
    localparam int RANDOM_BEATS   = 380;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 25;
    localparam int REPORT_LIMIT   = 10;

    typedef enum logic {
        ROW_BEAT = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    // One row of the directed table; typed rows carry their single expected value
    typedef struct packed {
        t_row_kind          kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               typed;
        logic [VALUE_W-1:0] typed_value;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [KEEP_W-1:0]   i_cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata;    // [31:0] sample_value
    logic                s_axis_tlast;    // end_of_array
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [VALUE_W-1:0]  m_axis_tdata;    // [31:0] kept_value
    logic                m_axis_tlast;    // last_of_run

    // Predictor state: keep setting and the values held, largest first
    logic [KEEP_W-1:0]         keep_setting;
    logic signed [VALUE_W-1:0] held_vals [MAX_KEPT];
    int unsigned               held_n;
    t_item                     pending_kept_q [$];

    bit    src_gaps_on;
    bit    sink_gaps_on;
    bit    sink_hold_req;
    int    mismatches;
    t_row  dir_rows [DIR_ROWS];
    t_item got_beat;
    t_item want_beat;

    wire src_beat  = s_axis_tvalid && s_axis_tready;
    wire sink_beat = m_axis_tvalid && m_axis_tready;

    streaming_k_smallest_tracker #(
        .MAX_KEPT (MAX_KEPT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Insert a value in descending order, duplicates after their equals
    function automatic void insert_held(input logic signed [VALUE_W-1:0] v);
        int unsigned pos;
        int unsigned i;
        if (held_n >= MAX_KEPT)
            return;
        pos = 0;
        while (pos < held_n && held_vals[pos] >= v)
            pos++;
        for (i = held_n; i > pos; i--)
            held_vals[i] = held_vals[i - 1];
        held_vals[pos] = v;
        held_n++;
    endfunction

    // Track one accepted sample; on the marked one, queue the held values and empty the store
    function automatic void track_sample(input logic signed [VALUE_W-1:0] v, input logic l,
                                         input bit record);
        int unsigned k;
        int unsigned i;
        t_item       r;
        k = (keep_setting > MAX_KEPT) ? MAX_KEPT : keep_setting;
        if (held_n < k) begin
            insert_held(v);
        end else if (held_n > 0 && v < held_vals[0]) begin
            for (i = 1; i < held_n; i++)
                held_vals[i - 1] = held_vals[i];
            held_n--;
            insert_held(v);
        end
        if (l) begin
            if (record) begin
                for (i = 0; i < held_n; i++) begin
                    r.value = held_vals[i];
                    r.last  = (i + 1 == held_n);
                    pending_kept_q.push_back(r);
                end
            end
            held_n = 0;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] rand_sample();
        logic [VALUE_W-1:0] s;
        case ($urandom_range(3))
            0: begin
                // narrow range, plenty of ties and sign changes
                s = $urandom_range(16);
                s = s - 32'd8;
            end
            1: begin
                case ($urandom_range(3))
                    0: s = 32'h7FFF_FFFF;
                    1: s = 32'h8000_0000;
                    2: s = 32'h0000_0000;
                    default: s = 32'hFFFF_FFFF;
                endcase
            end
            default: s = $urandom;
        endcase
        return s;
    endfunction

    function automatic void note_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                          input logic [VALUE_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Offer one beat with random gaps, then hand it to the predictor once accepted
    task automatic send_beat(input logic [VALUE_W-1:0] v, input logic l, input bit record);
        while (src_gaps_on && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        track_sample(v, l, record);
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every expected result, then let the queue run dry
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (pending_kept_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] kc);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= kc;
        keep_setting   = kc;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Sink ready: random gaps, plus one long hold-off on request
    initial begin : sink_drive
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= !(sink_gaps_on && $urandom_range(99) < 7);
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && sink_beat) begin
            got_beat.value = m_axis_tdata;
            got_beat.last  = m_axis_tlast;
            if (pending_kept_q.size() == 0) begin
                note_mismatch("unexpected beat", '0, got_beat.value);
            end else begin
                want_beat = pending_kept_q.pop_front();
                if (got_beat.value !== want_beat.value)
                    note_mismatch("kept_value", want_beat.value, got_beat.value);
                if (got_beat.last !== want_beat.last)
                    note_mismatch("last_of_run", want_beat.last, got_beat.last);
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        @(posedge i_rst_n);
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (src_beat || sink_beat)
                stalled = 0;
            else
                stalled++;
        end
        $display("tb_streaming_k_smallest_tracker: FAIL");
        $finish;
    end

    initial begin : stimulus
        int    row;
        int    beats_sent;
        int    phase;
        int    arrays;
        int    a;
        int    len;
        int    j;
        t_item typed_res;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        src_gaps_on   = 1'b1;
        sink_gaps_on  = 1'b1;
        sink_hold_req = 1'b0;
        mismatches    = 0;
        keep_setting  = 5'd1;
        held_n        = 0;

        // Directed table: kind, value (sample or keep), last, typed, typed value
        dir_rows = '{
            // extremes with the reset keep of one
            '{ROW_BEAT, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
            '{ROW_BEAT, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
            // a smaller value replaces, an equal one does not
            '{ROW_BEAT, 32'd5,         1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd3,         1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd3,         1'b1, 1'b1, 32'd3},
            // zero keep: nothing held, nothing emitted
            '{ROW_CFG,  32'd0,         1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd9,         1'b1, 1'b0, 32'd0},
            // keep above the store depth, with fewer samples than that
            '{ROW_CFG,  32'd31,        1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'h1234_5678, 1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'hFFFF_FFF9, 1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'h0000_0000, 1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd100,       1'b1, 1'b0, 32'd0},
            // duplicates kept
            '{ROW_CFG,  32'd2,         1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'hFFFF_FFFE, 1'b1, 1'b0, 32'd0},
            // keep lowered mid-array: the store keeps its size
            '{ROW_CFG,  32'd4,         1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd10,        1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd20,        1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd30,        1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd40,        1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd50,        1'b0, 1'b0, 32'd0},
            '{ROW_CFG,  32'd1,         1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd5,         1'b0, 1'b0, 32'd0},
            '{ROW_BEAT, 32'd60,        1'b1, 1'b0, 32'd0}
        };

        // Hold reset low, then release it on a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_rows[row].kind == ROW_CFG) begin
                drain_and_settle();
                write_keep(dir_rows[row].value[KEEP_W-1:0]);
            end else begin
                send_beat(dir_rows[row].value, dir_rows[row].last, !dir_rows[row].typed);
                if (dir_rows[row].typed) begin
                    typed_res.value = dir_rows[row].typed_value;
                    typed_res.last  = 1'b1;
                    pending_kept_q.push_back(typed_res);
                end
            end
        end

        // Random phases: new keep, one or more arrays of random length
        beats_sent = 0;
        phase      = 0;
        while (beats_sent < RANDOM_BEATS) begin
            drain_and_settle();
            case (phase % 6)
                0: write_keep(5'd1);
                1: write_keep(5'd16);
                2: write_keep(KEEP_W'($urandom_range(17, 31)));
                3: write_keep(5'd0);
                default: write_keep(KEEP_W'($urandom_range(1, 16)));
            endcase
            // one phase runs with no gaps on either side
            src_gaps_on  = (phase != 4);
            sink_gaps_on = (phase != 4);
            arrays = (phase % 6 == 3) ? 1 : $urandom_range(2, 5);
            for (a = 0; a < arrays; a++) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
                for (j = 0; j < len; j++) begin
                    // change the keep while an array is half done
                    if (phase % 4 == 2 && a == 0 && j > 0 && j == len / 2) begin
                        drain_and_settle();
                        write_keep(KEEP_W'($urandom_range(0, 20)));
                    end
                    // block the sink across a drain while samples keep coming
                    if (phase == 1 && a == 0 && j == len - 1)
                        sink_hold_req = 1'b1;
                    send_beat(rand_sample(), j == len - 1, 1'b1);
                    beats_sent++;
                end
            end
            phase++;
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("tb_streaming_k_smallest_tracker: PASS");
        else
            $display("tb_streaming_k_smallest_tracker: FAIL");
        $finish;
    end

endmodule

// ----- streaming_k_smallest_tracker.f -----
sv/skts_pkg.sv
sv/skts_front.sv
sv/skts_queue.sv
sv/skts_back.sv
sv/streaming_k_smallest_tracker.sv
sim/tb_streaming_k_smallest_tracker.sv
